// ===== design/lcc_pkg.sv =====
// lcc_pkg: shared types, constants and the filter arithmetic for the load
// continuity check. No dependencies; imported by load_continuity_check_core.
`timescale 1ns / 1ps

package lcc_pkg;

    // parameter defaults
    localparam int CURRENT_BITS_DEF = 16;
    localparam int TIMER_BITS_DEF   = 16;

    // field widths
    localparam int CUR_W   = 15;
    localparam int REF_W   = 16;
    localparam int ANGLE_W = 16;
    localparam int COEF_W  = 16;
    localparam int TICK_W  = 16;
    localparam int FILT_W  = 24;
    localparam int PHASE_W = 3;

    // configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    // stream widths
    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 56;

    // register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_CHECK_CURRENT  = 3'd0,
        REG_MIN_CURRENT    = 3'd1,
        REG_FIRST_WINDOW   = 3'd2,
        REG_SECOND_WINDOW  = 3'd3,
        REG_COEF_NEW       = 3'd4,
        REG_COEF_OLD       = 3'd5
    } cfg_reg_t;

    // phase codes reported on the output
    localparam logic [PHASE_W-1:0] PH_IDLE   = 3'd0;
    localparam logic [PHASE_W-1:0] PH_SETUP  = 3'd1;
    localparam logic [PHASE_W-1:0] PH_WIN1   = 3'd2;
    localparam logic [PHASE_W-1:0] PH_ROTATE = 3'd3;
    localparam logic [PHASE_W-1:0] PH_WIN2   = 3'd4;

    // check sequencer state
    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SETUP  = 5'b00010,
        ST_WIN1   = 5'b00100,
        ST_ROTATE = 5'b01000,
        ST_WIN2   = 5'b10000
    } check_state_t;

    // one low-pass step: ((cur * cn) >> 8) + ((filt * co) >> 16), saturated
    function automatic logic [FILT_W-1:0] filter_step(
        input logic [FILT_W-1:0] filt,
        input logic [CUR_W-1:0]  cur,
        input logic [COEF_W-1:0] cn,
        input logic [COEF_W-1:0] co
    );
        logic [CUR_W+COEF_W-1:0]  prod_new;
        logic [FILT_W+COEF_W-1:0] prod_old;
        logic [FILT_W:0]          sum;
        prod_new = (CUR_W+COEF_W)'(cur) * (CUR_W+COEF_W)'(cn);
        prod_old = (FILT_W+COEF_W)'(filt) * (FILT_W+COEF_W)'(co);
        sum = (FILT_W+1)'(prod_new[CUR_W+COEF_W-1:8])
            + (FILT_W+1)'(prod_old[FILT_W+COEF_W-1:16]);
        filter_step = sum[FILT_W] ? {FILT_W{1'b1}} : sum[FILT_W-1:0];
    endfunction

endpackage

// ===== design/load_continuity_check_core.sv =====
// Load continuity check: one request per PWM tick, one result per request.
// Latency: the result is registered and valid in the cycle after its request is accepted.
// Throughput: one request per cycle; a request is taken while the result
// register is empty or its result is being taken in the same cycle.
// Reset: sequencer to idle, filters, timer, held references, flags and all
// configuration registers to zero; no result pending.
`timescale 1ns / 1ps

module load_continuity_check_core
    import lcc_pkg::*;
#(
    parameter int CURRENT_BITS = CURRENT_BITS_DEF,
    parameter int TIMER_BITS   = TIMER_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // request stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // cur_u[14:0] cur_v[29:15] cur_w[44:30] id_ref_in[60:45]
    // iq_ref_in[76:61] angle_in[92:77], zero fill above
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // start_req[0]
    input  logic                  s_tuser,
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // id_ref_out[15:0] iq_ref_out[31:16] angle_out[47:32] fault[48]
    // force_speed[49] phase[52:50], zero fill above
    output logic [OUT_DATA_W-1:0] m_tdata
);

    // configuration registers
    logic [CUR_W-1:0]  check_current_reg;
    logic [CUR_W-1:0]  min_current_reg;
    logic [TICK_W-1:0] first_window_reg;
    logic [TICK_W-1:0] second_window_reg;
    logic [COEF_W-1:0] coef_new_reg;
    logic [COEF_W-1:0] coef_old_reg;

    // check state
    check_state_t            state_reg, state_next;
    logic [TIMER_BITS-1:0]   timer_reg, timer_next;
    logic [FILT_W-1:0]       filt_reg [3];
    logic [FILT_W-1:0]       filt_next [3];
    logic [CURRENT_BITS-1:0] id_held_reg, id_held_next;
    logic [CURRENT_BITS-1:0] iq_held_reg, iq_held_next;
    logic [ANGLE_W-1:0]      angle_held_reg, angle_held_next;
    logic                    fault_reg, fault_next;
    logic                    force_reg, force_next;
    logic                    out_valid_reg;

    // request fields
    logic                    start_req;
    logic [CUR_W-1:0]        cur_in [3];
    logic [REF_W-1:0]        id_ref_in;
    logic [REF_W-1:0]        iq_ref_in;
    logic [ANGLE_W-1:0]      angle_in;

    logic                    in_accept;
    logic                    min_low;
    logic [FILT_W-1:0]       filt_min;
    logic [FILT_W-1:0]       filt_step [3];
    logic [FILT_W-1:0]       filt_preload;
    logic [PHASE_W-1:0]      phase_code;

    // unpack the request
    assign start_req = s_tuser;
    assign cur_in[0] = s_tdata[14:0];
    assign cur_in[1] = s_tdata[29:15];
    assign cur_in[2] = s_tdata[44:30];
    assign id_ref_in = s_tdata[60:45];
    assign iq_ref_in = s_tdata[76:61];
    assign angle_in  = s_tdata[92:77];

    // result register parts the two sides
    assign s_tready  = !out_valid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;
    assign m_tvalid  = out_valid_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            check_current_reg <= '0;
            min_current_reg   <= '0;
            first_window_reg  <= '0;
            second_window_reg <= '0;
            coef_new_reg      <= '0;
            coef_old_reg      <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                REG_CHECK_CURRENT: check_current_reg <= cfg_wdata[CUR_W-1:0];
                REG_MIN_CURRENT:   min_current_reg   <= cfg_wdata[CUR_W-1:0];
                REG_FIRST_WINDOW:  first_window_reg  <= cfg_wdata;
                REG_SECOND_WINDOW: second_window_reg <= cfg_wdata;
                REG_COEF_NEW:      coef_new_reg      <= cfg_wdata;
                REG_COEF_OLD:      coef_old_reg      <= cfg_wdata;
                default:           ;
            endcase
        end
    end

    // per-phase filter lanes
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            filt_step[i] = filter_step(filt_reg[i], cur_in[i], coef_new_reg, coef_old_reg);
        end
    end

    // smallest filtered current against threshold (strictly less is low)
    always_comb
    begin
        filt_min = filt_reg[0];
        if (filt_reg[1] < filt_min)
        begin
            filt_min = filt_reg[1];
        end
        if (filt_reg[2] < filt_min)
        begin
            filt_min = filt_reg[2];
        end
    end
    assign min_low = filt_min < {1'b0, min_current_reg, 8'd0};

    // check_current / 2 in Q16.8
    assign filt_preload = {2'b00, check_current_reg, 7'd0};

    // sequencer next state
    always_comb
    begin
        state_next      = state_reg;
        timer_next      = timer_reg;
        filt_next       = filt_reg;
        id_held_next    = id_held_reg;
        iq_held_next    = iq_held_reg;
        angle_held_next = angle_held_reg;
        fault_next      = fault_reg;
        force_next      = force_reg;
        if (start_req)
        begin
            case (state_reg)
                ST_SETUP:
                begin
                    fault_next   = 1'b0;
                    iq_held_next = '0;
                    id_held_next = CURRENT_BITS'(check_current_reg);
                    timer_next   = TIMER_BITS'(first_window_reg);
                    for (int i = 0; i < 3; i++)
                    begin
                        filt_next[i] = filt_preload;
                    end
                    state_next   = ST_WIN1;
                end
                ST_WIN1, ST_WIN2:
                begin
                    if (timer_reg != '0)
                    begin
                        timer_next = timer_reg - TIMER_BITS'(1);
                        filt_next  = filt_step;
                    end
                    else if (min_low)
                    begin
                        if (state_reg == ST_WIN2)
                        begin
                            fault_next = 1'b1;
                        end
                        else
                        begin
                            state_next = ST_ROTATE;
                        end
                    end
                end
                ST_ROTATE:
                begin
                    id_held_next = CURRENT_BITS'(check_current_reg);
                    iq_held_next = CURRENT_BITS'(check_current_reg);
                    timer_next   = TIMER_BITS'(second_window_reg);
                    state_next   = ST_WIN2;
                end
                default:
                begin
                    state_next = ST_SETUP;
                end
            endcase
        end
        else
        begin
            force_next      = (state_reg != ST_IDLE);
            timer_next      = TIMER_BITS'(first_window_reg);
            state_next      = ST_IDLE;
            id_held_next    = CURRENT_BITS'(id_ref_in);
            iq_held_next    = CURRENT_BITS'(iq_ref_in);
            angle_held_next = angle_in;
            fault_next      = 1'b0;
        end
    end

    // state registers double as the result payload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            timer_reg      <= '0;
            filt_reg       <= '{default: '0};
            id_held_reg    <= '0;
            iq_held_reg    <= '0;
            angle_held_reg <= '0;
            fault_reg      <= 1'b0;
            force_reg      <= 1'b0;
        end
        else if (in_accept)
        begin
            state_reg      <= state_next;
            timer_reg      <= timer_next;
            filt_reg       <= filt_next;
            id_held_reg    <= id_held_next;
            iq_held_reg    <= iq_held_next;
            angle_held_reg <= angle_held_next;
            fault_reg      <= fault_next;
            force_reg      <= force_next;
        end
    end

    // result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // phase code for the result
    always_comb
    begin
        case (state_reg)
            ST_IDLE:   phase_code = PH_IDLE;
            ST_SETUP:  phase_code = PH_SETUP;
            ST_WIN1:   phase_code = PH_WIN1;
            ST_ROTATE: phase_code = PH_ROTATE;
            ST_WIN2:   phase_code = PH_WIN2;
            default:   phase_code = PH_IDLE;
        endcase
    end

    // pack the result
    assign m_tdata = {3'b000, phase_code, force_reg, fault_reg, angle_held_reg,
                      REF_W'(iq_held_reg), REF_W'(id_held_reg)};

    // fault only lives in the second window
    assert property (@(posedge clk) disable iff (!rst_n)
        fault_reg |-> (state_reg == ST_WIN2))
        else $error("fault set outside second window");

    // dropping start always returns to idle and clears the fault
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && !start_req) |=> (state_reg == ST_IDLE) && !fault_reg)
        else $error("start low did not return to idle");

    // force_speed reports whether a check was running
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && !start_req) |=> (force_reg == ($past(state_reg) != ST_IDLE)))
        else $error("force_speed mismatch");

    // running window counts down by one per accepted tick
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && start_req && (state_reg == ST_WIN1 || state_reg == ST_WIN2)
         && timer_reg != '0)
        |=> (timer_reg == $past(timer_reg) - TIMER_BITS'(1)))
        else $error("window timer did not count down");

    // state only moves on an accepted request
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_accept |=> $stable(state_reg) && $stable(timer_reg))
        else $error("state changed without a request");

endmodule

// ===== tb/sv/load_continuity_check_core_test.sv =====
// Self-checking bench for load_continuity_check_core: drives PWM tick requests
// and register writes, predicts every result and compares it field by field.
// Depends on lcc_pkg and load_continuity_check_core only.
`timescale 1ns / 1ps

module load_continuity_check_core_test
    import lcc_pkg::*;
();

    localparam int STALL_LIMIT = 4000;
    localparam int SINK_HOLD   = 300;

    // one PWM tick request and the outputs it produces
    typedef struct packed {
        logic        start_req;
        logic [14:0] cur_u;
        logic [14:0] cur_v;
        logic [14:0] cur_w;
        logic [15:0] id_ref;
        logic [15:0] iq_ref;
        logic [15:0] angle;
    } tick_req_t;

    typedef struct packed {
        logic [15:0]        id_ref;
        logic [15:0]        iq_ref;
        logic [15:0]        angle;
        logic               fault;
        logic               force_speed;
        logic [PHASE_W-1:0] phase;
    } tick_res_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // cur_u, cur_v, cur_w, id_ref_in, iq_ref_in, angle_in, zero fill
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    // start_req
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // id_ref_out, iq_ref_out, angle_out, fault, force_speed, phase, zero fill
    logic [OUT_DATA_W-1:0] m_tdata;

    // shadow copy of the configuration registers
    logic [14:0] chk_cur, min_cur;
    logic [15:0] win1_len, win2_len, wt_new, wt_old;

    // shadow copy of the check sequencer
    logic [PHASE_W-1:0] seq_phase;
    logic [15:0]        win_timer;
    logic [23:0]        flt_u, flt_v, flt_w;
    logic [15:0]        held_id, held_iq, held_angle;
    logic               held_fault, held_force;

    tick_res_t loop_outputs_due[$];

    bit gaps_on = 1'b0;
    bit sink_hold_req = 1'b0;
    bit sink_holding = 1'b0;
    int mismatches = 0;
    int reqs_sent = 0;
    int results_seen = 0;
    int settings_used = 0;
    int rotates_seen = 0;
    int faults_seen = 0;
    int aborts_seen = 0;
    int idle_cycles = 0;

    load_continuity_check_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // filter window length, kept short for most settings
    function automatic int pick_window();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 0;
        if (r < 85)
            return $urandom_range(1, 12);
        return $urandom_range(13, 60);
    endfunction

    function automatic tick_req_t tick_of(logic st, logic [14:0] u, logic [14:0] v,
                                          logic [14:0] w, logic [15:0] id,
                                          logic [15:0] iq, logic [15:0] ang);
        tick_req_t t;
        t.start_req = st;
        t.cur_u = u;
        t.cur_v = v;
        t.cur_w = w;
        t.id_ref = id;
        t.iq_ref = iq;
        t.angle = ang;
        return t;
    endfunction

    // random references, currents drawn from [lo, hi]
    function automatic tick_req_t rand_tick(logic st, int lo, int hi);
        return tick_of(st, 15'($urandom_range(hi, lo)), 15'($urandom_range(hi, lo)),
                       15'($urandom_range(hi, lo)), 16'($urandom_range(0, 65535)),
                       16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
    endfunction

    // Q16.8 low-pass update, both products truncated, sum clipped to 24 bits
    function automatic logic [23:0] lowpass_step(logic [23:0] acc, logic [14:0] sample);
        logic [63:0] from_sample, from_acc, total;
        from_sample = (64'(sample) * 64'(wt_new)) >> 8;
        from_acc = (64'(acc) * 64'(wt_old)) >> 16;
        total = from_sample + from_acc;
        return (total > 64'hFF_FFFF) ? 24'hFF_FFFF : total[23:0];
    endfunction

    // one tick inside a filter window, or the threshold test once it has run out
    function automatic void window_tick(tick_req_t t, bit second);
        logic [23:0] lowest;
        if (win_timer != 16'd0)
        begin
            win_timer = win_timer - 16'd1;
            flt_u = lowpass_step(flt_u, t.cur_u);
            flt_v = lowpass_step(flt_v, t.cur_v);
            flt_w = lowpass_step(flt_w, t.cur_w);
        end
        else
        begin
            lowest = flt_u;
            if (flt_v < lowest)
                lowest = flt_v;
            if (flt_w < lowest)
                lowest = flt_w;
            if (lowest < {1'b0, min_cur, 8'd0})
            begin
                if (second)
                begin
                    if (!held_fault)
                        faults_seen++;
                    held_fault = 1'b1;
                end
                else
                begin
                    seq_phase = PH_ROTATE;
                    rotates_seen++;
                end
            end
        end
    endfunction

    // advance the shadow sequencer by one request and return its outputs
    function automatic tick_res_t next_loop_outputs(tick_req_t t);
        tick_res_t o;
        if (t.start_req)
        begin
            case (seq_phase)
                PH_SETUP:
                begin
                    held_fault = 1'b0;
                    held_iq = '0;
                    held_id = {1'b0, chk_cur};
                    win_timer = win1_len;
                    flt_u = {2'b00, chk_cur, 7'd0};
                    flt_v = flt_u;
                    flt_w = flt_u;
                    seq_phase = PH_WIN1;
                end
                PH_WIN1: window_tick(t, 1'b0);
                PH_ROTATE:
                begin
                    held_id = {1'b0, chk_cur};
                    held_iq = held_id;
                    win_timer = win2_len;
                    seq_phase = PH_WIN2;
                end
                PH_WIN2: window_tick(t, 1'b1);
                default: seq_phase = PH_SETUP;
            endcase
        end
        else
        begin
            if (seq_phase != PH_IDLE)
                aborts_seen++;
            held_force = (seq_phase != PH_IDLE);
            win_timer = win1_len;
            seq_phase = PH_IDLE;
            held_id = t.id_ref;
            held_iq = t.iq_ref;
            held_angle = t.angle;
            held_fault = 1'b0;
        end
        o.id_ref = held_id;
        o.iq_ref = held_iq;
        o.angle = held_angle;
        o.fault = held_fault;
        o.force_speed = held_force;
        o.phase = seq_phase;
        return o;
    endfunction

    function automatic void check_field(string name, logic signed [31:0] want,
                                        logic signed [31:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // offer one request after an optional gap, predict once it is taken
    task automatic send_tick(input tick_req_t t);
        int gap;
        gap = gaps_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= t.start_req;
        s_tdata <= IN_DATA_W'({t.angle, t.iq_ref, t.id_ref, t.cur_w, t.cur_v, t.cur_u});
        do
            @(posedge clk);
        while (!s_tready);
        loop_outputs_due.push_back(next_loop_outputs(t));
        reqs_sent++;
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (loop_outputs_due.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // write all six registers, block must be drained
    task automatic program_regs(input logic [15:0] cc, input logic [15:0] mc,
                                input logic [15:0] w1, input logic [15:0] w2,
                                input logic [15:0] cn, input logic [15:0] co);
        logic [15:0] vals [6];
        vals = '{cc, mc, w1, w2, cn, co};
        for (int i = 0; i < 6; i++)
        begin
            cfg_wr_en <= 1'b1;
            cfg_addr <= cfg_reg_t'(i);
            cfg_wdata <= vals[i];
            @(posedge clk);
        end
        cfg_wr_en <= 1'b0;
        chk_cur = cc[14:0];
        min_cur = mc[14:0];
        win1_len = w1;
        win2_len = w2;
        wt_new = cn;
        wt_old = co;
        settings_used++;
    endtask

    // references and angle pass through with reset configuration
    task automatic test_passthrough();
        gaps_on = 1'b0;
        send_tick(tick_of(1'b0, 15'd0, 15'd0, 15'd0, 16'h8000, 16'h7FFF, 16'h0000));
        send_tick(tick_of(1'b0, 15'h7FFF, 15'h7FFF, 15'h7FFF, 16'h7FFF, 16'h8000, 16'hFFFF));
    endtask

    // zero registers: leave idle, empty window never counts as low, then abort
    task automatic test_zero_config();
        gaps_on = 1'b1;
        repeat (3) send_tick(rand_tick(1'b1, 0, 32767));
        send_tick(rand_tick(1'b0, 0, 32767));
    endtask

    // dead phases: full sequence through rotate to the fault, then abort
    task automatic test_open_phase();
        drain_results();
        program_regs(16'd1000, 16'd500, 16'd3, 16'd2, 16'h8000, 16'h8000);
        send_tick(rand_tick(1'b0, 0, 0));
        repeat (11) send_tick(rand_tick(1'b1, 0, 0));
        send_tick(rand_tick(1'b0, 0, 0));
    endtask

    // minimum equal to threshold is not low, one above it is
    task automatic test_threshold_edge();
        drain_results();
        program_regs(16'd1000, 16'd500, 16'd0, 16'd0, 16'd0, 16'd0);
        repeat (3) send_tick(rand_tick(1'b1, 0, 32767));
        drain_results();
        program_regs(16'd1000, 16'd501, 16'd0, 16'd0, 16'd0, 16'd0);
        repeat (3) send_tick(rand_tick(1'b1, 0, 32767));
    endtask

    // full-scale weights and currents drive the filter into saturation
    task automatic test_saturation();
        drain_results();
        program_regs(16'hFFFF, 16'd0, 16'd4, 16'd4, 16'hFFFF, 16'hFFFF);
        send_tick(rand_tick(1'b0, 0, 32767));
        repeat (4) send_tick(rand_tick(1'b1, 32767, 32767));
    endtask

    // result side stalls for a long stretch while requests keep coming
    task automatic test_backpressure();
        drain_results();
        gaps_on = 1'b0;
        send_tick(rand_tick(1'b0, 0, 32767));
        drain_results();
        sink_hold_req = 1'b1;
        wait (sink_holding);
        repeat (30) send_tick(rand_tick(1'b1, 0, 32767));
        drain_results();
    endtask

    // random settings, mostly well-formed check sequences with random content
    task automatic test_random_settings();
        logic [15:0] cc, mc, w1, w2, cn, co;
        int quota, sent, idle_run, run_len, lo, hi, kind;
        for (int s = 0; s < 12; s++)
        begin
            if (s == 0)
            begin
                {cc, mc, w1, w2, cn, co} = {6{16'hFFFF}};
                quota = 60;
            end
            else if (s == 1)
            begin
                {cc, mc, w1, w2, cn, co} = '0;
                quota = 80;
            end
            else
            begin
                cc = 16'($urandom_range(0, 65535));
                mc = 16'($urandom_range(0, 65535));
                w1 = 16'(pick_window());
                w2 = 16'(pick_window());
                cn = 16'($urandom_range(0, 65535));
                // weights usually sum to one so the filter settles at the sample
                if ($urandom_range(0, 9) < 7)
                    co = (cn == 16'd0) ? 16'hFFFF : 16'(17'h10000 - 17'(cn));
                else
                    co = 16'($urandom_range(0, 65535));
                quota = 185;
            end
            drain_results();
            program_regs(cc, mc, w1, w2, cn, co);
            sent = 0;
            while (sent < quota)
            begin
                gaps_on = ($urandom_range(0, 4) != 0);
                idle_run = $urandom_range(1, 3);
                repeat (idle_run) send_tick(rand_tick(1'b0, 0, 32767));
                run_len = int'(w1) + int'(w2) + 4 + $urandom_range(0, 5);
                if (run_len > 80)
                    run_len = 80;
                // some checks get cut short
                if ($urandom_range(0, 4) == 0)
                    run_len = $urandom_range(1, run_len);
                kind = $urandom_range(0, 2);
                lo = (kind == 1) ? int'(mc[14:0]) : 0;
                hi = (kind == 0) ? ((mc[14:0] == 15'd0) ? 0 : int'(mc[14:0]) - 1) : 32767;
                repeat (run_len)
                    send_tick(rand_tick(($urandom_range(0, 19) == 0) ?
                                        1'($urandom_range(0, 1)) : 1'b1, lo, hi));
                sent += idle_run + run_len;
                if ($urandom_range(0, 15) == 0)
                    drain_results();
            end
        end
    endtask

    // result sink: random stalls, plus one long hold on request
    initial
    begin : result_sink
        int n;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (sink_hold_req)
            begin
                sink_holding = 1'b1;
                m_tready <= 1'b0;
                repeat (SINK_HOLD) @(posedge clk);
                sink_holding = 1'b0;
                sink_hold_req = 1'b0;
            end
            else
            begin
                n = gaps_on ? pick_gap() : 0;
                if (n > 0)
                begin
                    m_tready <= 1'b0;
                    repeat (n) @(posedge clk);
                end
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
    end

    // compare each accepted result with the oldest prediction
    always @(posedge clk)
    begin : result_check
        tick_res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (loop_outputs_due.size() == 0)
            begin
                $error("result %h arrived with no request outstanding", m_tdata);
                mismatches++;
            end
            else
            begin
                want = loop_outputs_due.pop_front();
                check_field("id_ref_out", $signed(want.id_ref), $signed(m_tdata[15:0]));
                check_field("iq_ref_out", $signed(want.iq_ref), $signed(m_tdata[31:16]));
                check_field("angle_out", want.angle, m_tdata[47:32]);
                check_field("fault", want.fault, m_tdata[48]);
                check_field("force_speed", want.force_speed, m_tdata[49]);
                check_field("phase", want.phase, m_tdata[52:50]);
            end
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("[load_continuity_check_core] ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // reset, then the tests in turn
    initial
    begin
        chk_cur = '0;
        min_cur = '0;
        win1_len = '0;
        win2_len = '0;
        wt_new = '0;
        wt_old = '0;
        seq_phase = PH_IDLE;
        win_timer = '0;
        flt_u = '0;
        flt_v = '0;
        flt_w = '0;
        held_id = '0;
        held_iq = '0;
        held_angle = '0;
        held_fault = 1'b0;
        held_force = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_passthrough();
        test_zero_config();
        test_open_phase();
        test_threshold_edge();
        test_saturation();
        test_backpressure();
        test_random_settings();
        drain_results();

        $display("covered %0d tick requests and %0d results over %0d register settings",
                 reqs_sent, results_seen, settings_used);
        $display("checks reaching rotate: %0d, open-phase faults: %0d, aborted checks: %0d",
                 rotates_seen, faults_seen, aborts_seen);
        if (mismatches == 0 && loop_outputs_due.size() == 0)
            $display("[load_continuity_check_core] OK");
        else
            $display("[load_continuity_check_core] ERROR");
        $finish;
    end

endmodule
